// ----- hw/rtl/kcc_pkg.sv -----
package kcc_pkg;

  localparam logic [2:0] MODE_LOAD_PIX = 3'd0;
  localparam logic [2:0] MODE_LOAD_CEN = 3'd1;
  localparam logic [2:0] MODE_RUN      = 3'd2;
  localparam logic [2:0] MODE_RD_LBL   = 3'd3;
  localparam logic [2:0] MODE_RD_CEN   = 3'd4;

  localparam logic [1:0] CFG_NUM_CLUSTERS   = 2'd0;
  localparam logic [1:0] CFG_NUM_POINTS     = 2'd1;
  localparam logic [1:0] CFG_MAX_ITERATIONS = 2'd2;

  localparam int DIST_W = 18;
  localparam int CHAN_W = 8;

  typedef struct packed {
    logic clr_label;
    logic load_pix;
    logic load_cen;
    logic read_lbl;
    logic read_cen;
    logic read_cap;
    logic run_start;
    logic run_end;
    logic pass_start;
    logic pass_end;
    logic clr_acc;
    logic pix_fetch;
    logic dist_step;
    logic dist_first;
    logic acc_fetch;
    logic acc_write;
    logic upd_fetch;
    logic div_load;
    logic div_step;
    logic cen_write;
  } kcc_cmd_t;

  typedef struct packed {
    logic run_go;
    logic out_block;
  } kcc_status_t;

endpackage

// ----- hw/rtl/kcc_datapath.sv -----
module kcc_datapath import kcc_pkg::*; #(
  parameter int MAX_POINTS   = 4096,
  parameter int MAX_CLUSTERS = 16,
  parameter int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  parameter int CAW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  kcc_cmd_t         cmd,
  input  logic [11:0]      in_index,
  input  logic [7:0]       in_red,
  input  logic [7:0]       in_green,
  input  logic [7:0]       in_blue,
  input  logic [PAW-1:0]   p_addr,
  input  logic [CAW-1:0]   j_addr,
  input  logic [CAW-1:0]   cen_addr,
  input  logic [2:0]       b_sel,
  input  logic [9:0]       max_iter,
  input  logic             out_stall,
  output kcc_status_t      status,
  output logic             out_valid,
  output logic [3:0]       out_cluster,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [9:0]       out_iterations,
  output logic             out_converged
);

  localparam int LW  = $clog2(MAX_CLUSTERS + 1);
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int SW  = $clog2(255 * MAX_POINTS + 1);
  localparam int DW  = PCW + 8;
  localparam int AW  = PCW + 3 * SW;

  logic [23:0]   pix_mem [MAX_POINTS];
  logic [LW-1:0] lbl_mem [MAX_POINTS];
  logic [23:0]   cen_mem [MAX_CLUSTERS];
  logic [AW-1:0] acc_mem [MAX_CLUSTERS];

  logic [23:0]       pix_rd_r;
  logic [LW-1:0]     lbl_rd_r;
  logic [23:0]       cen_rd_r;
  logic [AW-1:0]     acc_rd_r;
  logic [CAW-1:0]    best_r;
  logic [DIST_W-1:0] best_d_r;
  logic [DW-1:0]     rem_r [3];
  logic [7:0]        q_r [3];
  logic [PCW-1:0]    cnt_r;
  logic [9:0]        iter_r;
  logic              changed_r;
  logic              rd_ok_r;
  logic              rd_is_lbl_r;
  logic              out_valid_r;
  logic [3:0]        cluster_r;
  logic [7:0]        red_r, green_r, blue_r;
  logic [9:0]        iters_r;
  logic              conv_r;

  logic [31:0]       idx32;
  logic [PAW-1:0]    idx_p;
  logic [CAW-1:0]    idx_c;
  logic              idx_p_ok, idx_c_ok;
  logic [CAW-1:0]    cen_raddr;
  logic [LW-1:0]     lbl_raddr_sel;
  logic [DIST_W-1:0] dist_sq;
  logic [PAW-1:0]    lbl_raddr;
  logic [CAW-1:0]    acc_addr;
  logic [AW-1:0]     acc_sum;
  logic [DW-1:0]     den;
  logic [31:0]       lbl32;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? a - b : b - a;
    return 16'(d * d);
  endfunction

  assign idx32     = 32'(in_index);
  assign idx_p     = idx32[PAW-1:0];
  assign idx_c     = idx32[CAW-1:0];
  assign idx_p_ok  = idx32 < MAX_POINTS;
  assign idx_c_ok  = idx32 < MAX_CLUSTERS;
  assign cen_raddr = cmd.read_cen ? idx_c : cen_addr;
  assign lbl_raddr = cmd.read_lbl ? idx_p : p_addr;
  assign acc_addr  = (cmd.acc_fetch || cmd.acc_write) ? best_r : j_addr;
  assign lbl_raddr_sel = LW'(best_r);

  assign dist_sq = DIST_W'(sq_diff(pix_rd_r[23:16], cen_rd_r[23:16]))
                 + DIST_W'(sq_diff(pix_rd_r[15:8],  cen_rd_r[15:8]))
                 + DIST_W'(sq_diff(pix_rd_r[7:0],   cen_rd_r[7:0]));

  assign acc_sum = {acc_rd_r[AW-1 -: PCW] + PCW'(1),
                    acc_rd_r[3*SW-1 -: SW] + SW'(pix_rd_r[23:16]),
                    acc_rd_r[2*SW-1 -: SW] + SW'(pix_rd_r[15:8]),
                    acc_rd_r[SW-1:0]       + SW'(pix_rd_r[7:0])};

  assign den   = DW'(cnt_r) << b_sel;
  assign lbl32 = 32'(lbl_rd_r);

  always_ff @(posedge clk) begin
    if (cmd.load_pix && idx_p_ok) begin
      pix_mem[idx_p] <= {in_red, in_green, in_blue};
    end
    if (cmd.pix_fetch) begin
      pix_rd_r <= pix_mem[p_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_label) begin
      lbl_mem[p_addr] <= LW'(MAX_CLUSTERS);
    end else if (cmd.acc_fetch && lbl_rd_r != lbl_raddr_sel) begin
      lbl_mem[p_addr] <= lbl_raddr_sel;
    end
    if (cmd.pix_fetch || cmd.read_lbl) begin
      lbl_rd_r <= lbl_mem[lbl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cen && idx_c_ok) begin
      cen_mem[idx_c] <= {in_red, in_green, in_blue};
    end else if (cmd.cen_write && cnt_r != '0) begin
      cen_mem[j_addr] <= {q_r[0], q_r[1], q_r[2]};
    end
    cen_rd_r <= cen_mem[cen_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_acc) begin
      acc_mem[acc_addr] <= '0;
    end else if (cmd.acc_write) begin
      acc_mem[acc_addr] <= acc_sum;
    end
    if (cmd.acc_fetch || cmd.upd_fetch) begin
      acc_rd_r <= acc_mem[acc_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dist_step && (cmd.dist_first || dist_sq < best_d_r)) begin
      best_d_r <= dist_sq;
      best_r   <= j_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      cnt_r    <= acc_rd_r[AW-1 -: PCW];
      rem_r[0] <= DW'(acc_rd_r[3*SW-1 -: SW]);
      rem_r[1] <= DW'(acc_rd_r[2*SW-1 -: SW]);
      rem_r[2] <= DW'(acc_rd_r[SW-1:0]);
      for (int c = 0; c < 3; c++) begin
        q_r[c] <= '0;
      end
    end else if (cmd.div_step) begin
      for (int c = 0; c < 3; c++) begin
        if (rem_r[c] >= den) begin
          rem_r[c] <= rem_r[c] - den;
          q_r[c]   <= {q_r[c][6:0], 1'b1};
        end else begin
          q_r[c]   <= {q_r[c][6:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r    <= '0;
      changed_r <= 1'b0;
    end else begin
      if (cmd.run_start) begin
        iter_r    <= '0;
        changed_r <= 1'b1;
      end else if (cmd.pass_start) begin
        changed_r <= 1'b0;
      end else if (cmd.acc_fetch && lbl_rd_r != lbl_raddr_sel) begin
        changed_r <= 1'b1;
      end
      if (cmd.pass_end) begin
        iter_r <= iter_r + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_lbl || cmd.read_cen) begin
      rd_is_lbl_r <= cmd.read_lbl;
      rd_ok_r     <= cmd.read_lbl ? idx_p_ok : idx_c_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.read_cap || cmd.run_end) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_cap || cmd.run_end) begin
      iters_r   <= iter_r;
      conv_r    <= (iter_r != '0) && !changed_r;
      cluster_r <= '0;
      red_r     <= '0;
      green_r   <= '0;
      blue_r    <= '0;
      if (cmd.read_cap && rd_ok_r) begin
        if (rd_is_lbl_r) begin
          if (lbl_rd_r < LW'(MAX_CLUSTERS)) begin
            cluster_r <= lbl32[3:0];
          end
        end else begin
          red_r   <= cen_rd_r[23:16];
          green_r <= cen_rd_r[15:8];
          blue_r  <= cen_rd_r[7:0];
        end
      end
    end
  end

  assign status.run_go    = changed_r && (iter_r < max_iter);
  assign status.out_block = out_valid_r && out_stall;

  assign out_valid      = out_valid_r;
  assign out_cluster    = cluster_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_iterations = iters_r;
  assign out_converged  = conv_r;

endmodule

// ----- hw/rtl/kcc_controller.sv -----
module kcc_controller import kcc_pkg::*; #(
  parameter int MAX_POINTS   = 4096,
  parameter int MAX_CLUSTERS = 16,
  parameter int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  parameter int CAW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [2:0]     in_mode,
  output logic           in_stall,
  input  logic [4:0]     num_clusters,
  input  logic [12:0]    num_points,
  input  kcc_status_t    status,
  output kcc_cmd_t       cmd,
  output logic [PAW-1:0] p_addr,
  output logic [CAW-1:0] j_addr,
  output logic [CAW-1:0] cen_addr,
  output logic [2:0]     b_sel
);

  localparam int PCW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_CLRACC = 4'd4;
  localparam logic [3:0] S_PIXRD  = 4'd5;
  localparam logic [3:0] S_DIST   = 4'd6;
  localparam logic [3:0] S_ACCRD  = 4'd7;
  localparam logic [3:0] S_ACCWR  = 4'd8;
  localparam logic [3:0] S_UPDRD  = 4'd9;
  localparam logic [3:0] S_DIVLD  = 4'd10;
  localparam logic [3:0] S_DIV    = 4'd11;
  localparam logic [3:0] S_CENWR  = 4'd12;

  logic [3:0]     state_r, state_nxt;
  logic [PCW-1:0] p_r, p_nxt;
  logic [CAW-1:0] j_r, j_nxt;
  logic [2:0]     b_r, b_nxt;
  logic [31:0]    k32, n32, kl32;
  logic [CAW-1:0] k_last;
  logic [PCW-1:0] n_eff;
  logic           accept;

  always_comb begin
    k32 = 32'(num_clusters);
    if (k32 == 0) begin
      k32 = 1;
    end else if (k32 > MAX_CLUSTERS) begin
      k32 = MAX_CLUSTERS;
    end
    kl32 = k32 - 1;
    n32  = 32'(num_points);
    if (n32 > MAX_POINTS) begin
      n32 = MAX_POINTS;
    end
  end

  assign k_last   = kl32[CAW-1:0];
  assign n_eff    = n32[PCW-1:0];
  assign in_stall = (state_r != S_IDLE) || status.out_block;
  assign accept   = in_valid && !in_stall;
  assign p_addr   = p_r[PAW-1:0];
  assign j_addr   = j_r;
  assign b_sel    = b_r;

  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    j_nxt     = j_r;
    b_nxt     = b_r;
    cmd       = '0;
    cen_addr  = j_r;
    case (state_r)
      S_INIT: begin
        cmd.clr_label = 1'b1;
        if (p_r == PCW'(MAX_POINTS - 1)) begin
          p_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          p_nxt = p_r + PCW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_LOAD_PIX: cmd.load_pix = 1'b1;
            MODE_LOAD_CEN: cmd.load_cen = 1'b1;
            MODE_RUN: begin
              cmd.run_start = 1'b1;
              state_nxt     = S_CHECK;
            end
            MODE_RD_LBL: begin
              cmd.read_lbl = 1'b1;
              state_nxt    = S_RD;
            end
            MODE_RD_CEN: begin
              cmd.read_cen = 1'b1;
              state_nxt    = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        cmd.read_cap = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_CHECK: begin
        if (status.run_go) begin
          cmd.pass_start = 1'b1;
          j_nxt          = '0;
          state_nxt      = S_CLRACC;
        end else begin
          cmd.run_end = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_CLRACC: begin
        cmd.clr_acc = 1'b1;
        if (j_r == k_last) begin
          p_nxt     = '0;
          state_nxt = S_PIXRD;
        end else begin
          j_nxt = j_r + CAW'(1);
        end
      end
      S_PIXRD: begin
        j_nxt = '0;
        if (p_r == n_eff) begin
          state_nxt = S_UPDRD;
        end else begin
          cmd.pix_fetch = 1'b1;
          cen_addr      = '0;
          state_nxt     = S_DIST;
        end
      end
      S_DIST: begin
        cmd.dist_step  = 1'b1;
        cmd.dist_first = (j_r == '0);
        cen_addr       = j_r + CAW'(1);
        if (j_r == k_last) begin
          state_nxt = S_ACCRD;
        end else begin
          j_nxt = j_r + CAW'(1);
        end
      end
      S_ACCRD: begin
        cmd.acc_fetch = 1'b1;
        state_nxt     = S_ACCWR;
      end
      S_ACCWR: begin
        cmd.acc_write = 1'b1;
        p_nxt         = p_r + PCW'(1);
        state_nxt     = S_PIXRD;
      end
      S_UPDRD: begin
        cmd.upd_fetch = 1'b1;
        state_nxt     = S_DIVLD;
      end
      S_DIVLD: begin
        cmd.div_load = 1'b1;
        b_nxt        = 3'd7;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (b_r == 3'd0) begin
          state_nxt = S_CENWR;
        end else begin
          b_nxt = b_r - 3'd1;
        end
      end
      S_CENWR: begin
        cmd.cen_write = 1'b1;
        if (j_r == k_last) begin
          cmd.pass_end = 1'b1;
          state_nxt    = S_CHECK;
        end else begin
          j_nxt     = j_r + CAW'(1);
          state_nxt = S_UPDRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      p_r     <= '0;
      j_r     <= '0;
      b_r     <= '0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      j_r     <= j_nxt;
      b_r     <= b_nxt;
    end
  end

  a_dist_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIST |-> $past(state_r) == S_PIXRD || $past(state_r) == S_DIST)
    else $error("distance scan entered without a pixel fetch");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIVLD |=> state_r == S_DIV && b_r == 3'd7)
    else $error("divider did not start at the top quotient bit");

  a_read_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> $past(state_r) == S_IDLE && $past(accept))
    else $error("read capture without an accepted read beat");

endmodule

// ----- hw/rtl/kmeans_color_clustering.sv -----
// Channel  Ports                                                    Handshake
// in       in_mode in_index in_red in_green in_blue                 in_valid / in_stall
// out      out_cluster out_red out_green out_blue out_iterations    out_valid / out_stall
//          out_converged
// cfg      cfg_index cfg_data                                       cfg_we
//
// After reset the label store is swept to "none", entry by entry, with in_stall high.
// A load beat writes its store directly; a read beat passes through S_RD, which captures the registered memory read.
// During a run beat, per pixel the distance
// unit compares one centroid per cycle; per cluster, the mean divider resolves one bit a cycle.
// in_stall is high while a beat is in progress or a finished result waits behind out_stall.
module kmeans_color_clustering import kcc_pkg::*; #(
  parameter int MAX_POINTS   = 4096,
  parameter int MAX_CLUSTERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [11:0] in_index,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_cluster,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [9:0]  out_iterations,
  output logic        out_converged,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CAW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

  logic [4:0]  num_clusters_r;
  logic [12:0] num_points_r;
  logic [9:0]  max_iter_r;

  kcc_cmd_t       cmd;
  kcc_status_t    status;
  logic [PAW-1:0] p_addr;
  logic [CAW-1:0] j_addr;
  logic [CAW-1:0] cen_addr;
  logic [2:0]     b_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_clusters_r <= 5'd8;
      num_points_r   <= 13'd4096;
      max_iter_r     <= 10'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_CLUSTERS:   num_clusters_r <= cfg_data[4:0];
        CFG_NUM_POINTS:     num_points_r   <= cfg_data;
        CFG_MAX_ITERATIONS: max_iter_r     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  kcc_controller #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .PAW          (PAW),
    .CAW          (CAW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_mode      (in_mode),
    .in_stall     (in_stall),
    .num_clusters (num_clusters_r),
    .num_points   (num_points_r),
    .status       (status),
    .cmd          (cmd),
    .p_addr       (p_addr),
    .j_addr       (j_addr),
    .cen_addr     (cen_addr),
    .b_sel        (b_sel)
  );

  kcc_datapath #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .PAW          (PAW),
    .CAW          (CAW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_index       (in_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .p_addr         (p_addr),
    .j_addr         (j_addr),
    .cen_addr       (cen_addr),
    .b_sel          (b_sel),
    .max_iter       (max_iter_r),
    .out_stall      (out_stall),
    .status         (status),
    .out_valid      (out_valid),
    .out_cluster    (out_cluster),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_iterations (out_iterations),
    .out_converged  (out_converged)
  );

endmodule

// ----- dv/kmeans_color_clustering_tb.sv -----
module kmeans_color_clustering_tb;
  import kcc_pkg::*;

  localparam int NPIX = 4096;
  localparam int NCEN = 16;
  localparam int NLOAD = 256;
  localparam int LABEL_NONE = 16;
  localparam int STALL_LIMIT = 300000;

  typedef struct packed {
    logic [3:0] cluster;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] iterations;
    logic       converged;
  } color_result_t;

  class kmeans_scoreboard;
    logic [23:0] pixels[NPIX];
    logic [4:0]  labels[NPIX];
    logic [23:0] centroids[NCEN];
    int unsigned k_cfg, n_cfg, iter_cfg;
    int unsigned pass_count;
    bit          label_moved;
    color_result_t pending_results[$];
    int unsigned errors;

    function new();
      foreach (labels[i]) labels[i] = 5'(LABEL_NONE);
      k_cfg = 8;
      n_cfg = 4096;
      iter_cfg = 1000;
      pass_count = 0;
      label_moved = 0;
      errors = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [12:0] data);
      case (idx)
        CFG_NUM_CLUSTERS:   k_cfg = data[4:0];
        CFG_NUM_POINTS:     n_cfg = data[12:0];
        CFG_MAX_ITERATIONS: iter_cfg = data[9:0];
        default: ;
      endcase
    endfunction

    function int unsigned color_dist(logic [23:0] a, logic [23:0] b);
      int unsigned s;
      int d;
      s = 0;
      for (int c = 0; c < 3; c++) begin
        d = int'(a[16 - 8 * c +: 8]) - int'(b[16 - 8 * c +: 8]);
        s += d * d;
      end
      return s;
    endfunction

    function void run_lloyd();
      int unsigned k, n, best, bestd, d;
      int unsigned sums[NCEN * 3];
      int unsigned counts[NCEN];
      logic [23:0] rgb;
      k = (k_cfg == 0) ? 1 : (k_cfg > NCEN) ? NCEN : k_cfg;
      n = (n_cfg > NPIX) ? NPIX : n_cfg;
      pass_count = 0;
      label_moved = 1;
      while (label_moved && pass_count < iter_cfg) begin
        label_moved = 0;
        foreach (sums[i]) sums[i] = 0;
        foreach (counts[i]) counts[i] = 0;
        for (int p = 0; p < n; p++) begin
          best = 0;
          bestd = color_dist(pixels[p], centroids[0]);
          for (int j = 1; j < k; j++) begin
            d = color_dist(pixels[p], centroids[j]);
            if (d < bestd) begin
              bestd = d;
              best = j;
            end
          end
          if (labels[p] != best) begin
            labels[p] = 5'(best);
            label_moved = 1;
          end
        end
        for (int p = 0; p < n; p++) begin
          if (labels[p] < k) begin
            for (int c = 0; c < 3; c++)
              sums[labels[p] * 3 + c] += pixels[p][16 - 8 * c +: 8];
            counts[labels[p]]++;
          end
        end
        for (int j = 0; j < k; j++) begin
          if (counts[j] != 0) begin
            for (int c = 0; c < 3; c++)
              rgb[16 - 8 * c +: 8] = 8'(sums[j * 3 + c] / counts[j]);
            centroids[j] = rgb;
          end
        end
        pass_count++;
      end
    endfunction

    function void note_input(logic [2:0] mode, logic [11:0] idx, logic [23:0] rgb);
      color_result_t r;
      r = '0;
      case (mode)
        MODE_LOAD_PIX: begin
          pixels[idx] = rgb;
          return;
        end
        MODE_LOAD_CEN: begin
          if (idx < NCEN) centroids[idx] = rgb;
          return;
        end
        MODE_RUN: run_lloyd();
        MODE_RD_LBL: if (labels[idx] < NCEN) r.cluster = labels[idx][3:0];
        MODE_RD_CEN: if (idx < NCEN) {r.red, r.green, r.blue} = centroids[idx];
        default: return;
      endcase
      r.iterations = 10'(pass_count);
      r.converged = (pass_count != 0) && !label_moved;
      pending_results.push_back(r);
    endfunction

    function void check_result(color_result_t got);
      color_result_t exp;
      if (pending_results.size() == 0) begin
        $error("Result beat with no expected result: %p", got);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.cluster != exp.cluster) begin
        $error("cluster: expected %0d, actual %0d", exp.cluster, got.cluster);
        errors++;
      end
      if (got.red != exp.red) begin
        $error("out_red: expected %0d, actual %0d", exp.red, got.red);
        errors++;
      end
      if (got.green != exp.green) begin
        $error("out_green: expected %0d, actual %0d", exp.green, got.green);
        errors++;
      end
      if (got.blue != exp.blue) begin
        $error("out_blue: expected %0d, actual %0d", exp.blue, got.blue);
        errors++;
      end
      if (got.iterations != exp.iterations) begin
        $error("out_iterations: expected %0d, actual %0d", exp.iterations, got.iterations);
        errors++;
      end
      if (got.converged != exp.converged) begin
        $error("out_converged: expected %0d, actual %0d", exp.converged, got.converged);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_mode;
  logic [11:0] in_index;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_cluster;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [9:0]  out_iterations;
  logic        out_converged;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;

  kmeans_scoreboard sb;
  bit calm;
  bit long_hold;
  int items_sent;
  int idle_cycles;

  kmeans_color_clustering uut (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_cluster, out_red, out_green, out_blue, out_iterations, out_converged});
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18) - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 25)) @(posedge clk);
      end
    end
  end

  task automatic send(logic [2:0] mode, logic [11:0] idx, logic [23:0] rgb);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_index <= idx;
    {in_red, in_green, in_blue} <= rgb;
    do @(posedge clk); while (in_stall);
    sb.note_input(mode, idx, rgb);
    items_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic configure(int unsigned k, int unsigned n, int unsigned iters);
    drain();
    write_reg(CFG_NUM_CLUSTERS, 13'(k));
    write_reg(CFG_NUM_POINTS, 13'(n));
    write_reg(CFG_MAX_ITERATIONS, 13'(iters));
    cfg_we <= 1'b0;
  endtask

  task automatic random_item(int unsigned span);
    int unsigned pick;
    logic [23:0] rgb;
    pick = $urandom_range(0, 99);
    rgb = 24'($urandom);
    if (pick < 35)
      send(MODE_LOAD_PIX,
           12'((pick < 30) ? $urandom_range(0, span) : $urandom_range(0, 4095)), rgb);
    else if (pick < 47)
      send(MODE_LOAD_CEN,
           12'((pick < 45) ? $urandom_range(0, 15) : $urandom_range(0, 4095)), rgb);
    else if (pick < 55)
      send(MODE_RUN, 12'($urandom), rgb);
    else if (pick < 75)
      send(MODE_RD_LBL,
           12'((pick < 70) ? $urandom_range(0, span) : $urandom_range(0, 4095)), rgb);
    else if (pick < 95)
      send(MODE_RD_CEN,
           12'((pick < 92) ? $urandom_range(0, 15) : $urandom_range(0, 4095)), rgb);
    else
      send(3'($urandom_range(5, 7)), 12'($urandom), rgb);
  endtask

  initial begin
    int unsigned k, n, iters;
    sb = new();
    calm = 0;
    long_hold = 0;
    items_sent = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_LOAD_PIX;
    in_index = '0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_NUM_CLUSTERS;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send(MODE_RD_LBL, 12'd0, 24'h0);
    send(MODE_RD_LBL, 12'd4095, 24'h0);
    for (int i = 0; i < NLOAD; i++)
      send(MODE_LOAD_PIX, 12'(i),
           (i == 0) ? 24'h000000 : (i == 1) ? 24'hffffff : 24'($urandom));
    for (int j = 0; j < NCEN; j++)
      send(MODE_LOAD_CEN, 12'(j),
           (j == 0) ? 24'h000000 : (j == 15) ? 24'hffffff : 24'($urandom));
    send(MODE_LOAD_CEN, 12'd4095, 24'h123456);
    send(MODE_RD_CEN, 12'd0, 24'h0);
    send(MODE_RD_CEN, 12'd15, 24'h0);
    send(MODE_RD_CEN, 12'd16, 24'h0);
    send(MODE_RD_CEN, 12'd4095, 24'h0);
    send(3'd5, 12'd1, 24'hffffff);
    send(3'd6, 12'd2, 24'h0);
    send(3'd7, 12'hfff, 24'hffffff);

    configure(8, 4096, 0);
    send(MODE_RUN, 12'd0, 24'h0);
    configure(16, NLOAD, 1);
    send(MODE_RUN, 12'd0, 24'h0);
    send(MODE_RD_LBL, 12'd4095, 24'h0);
    configure(0, 0, 1000);
    send(MODE_RUN, 12'd0, 24'h0);
    send(MODE_RD_CEN, 12'd0, 24'h0);
    configure(31, NLOAD, 2);
    send(MODE_RUN, 12'd0, 24'h0);
    send(MODE_RD_LBL, 12'd100, 24'h0);
    configure(1, 4, 1000);
    send(MODE_RUN, 12'd0, 24'h0);
    send(MODE_RD_CEN, 12'd0, 24'h0);
    configure(16, 6, 1000);
    send(MODE_RUN, 12'd0, 24'h0);

    drain();
    long_hold = 1;
    for (int i = 0; i < 20; i++) send(MODE_RD_CEN, 12'($urandom_range(0, 15)), 24'h0);

    while (items_sent < 950) begin
      if (items_sent > 820) calm = 1;
      case ($urandom_range(0, 9))
        0: k = $urandom_range(0, 31);
        1: k = 16;
        default: k = $urandom_range(1, 16);
      endcase
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 64);
      iters = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 40);
      configure(k, n, iters);
      repeat ($urandom_range(10, 40)) random_item(n + 4);
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- kmeans_color_clustering.f -----
hw/rtl/kcc_pkg.sv
hw/rtl/kcc_datapath.sv
hw/rtl/kcc_controller.sv
hw/rtl/kmeans_color_clustering.sv
dv/kmeans_color_clustering_tb.sv
